>>> design/fmam_pkg.sv
package fmam_pkg;

  // Field and register widths.
  localparam int AUDIO_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int STEP_W      = 23;
  localparam int MODE_W      = 2;
  localparam int SAMPLE_W    = 8;
  localparam int MAG_W       = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 23;

  // Saturated amplitude is Q1.15 held in 17 bits, so that +1.0 fits.
  localparam int AMP_W         = 17;
  localparam int AMP_FRAC_BITS = 15;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int PROD_W        = AUDIO_W + GAIN_W + 1;
  // Shared back-end multiplier: signed step (or 127) times amplitude.
  localparam int MUL_A_W       = STEP_W + 1;
  localparam int MUL_W         = MUL_A_W + AMP_W;
  localparam int DELTA_W       = MUL_W - AMP_FRAC_BITS;

  // Defaults of the top-level parameters.
  localparam int PHASE_BITS_DEF      = 24;
  localparam int TABLE_ADDR_BITS_DEF = 10;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AUDIO_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_STEP   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NARROW_STEP = 3'd3;

  // Mode codes. The upper bit alone selects AM.
  localparam logic [MODE_W-1:0] MODE_WIDE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NARROW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AM     = 2'd2;

  // Reset values of the registers.
  localparam logic [MODE_W-1:0] MODE_RST        = MODE_WIDE;
  localparam logic [GAIN_W-1:0] AUDIO_GAIN_RST  = 16'd256;
  localparam logic [STEP_W-1:0] WIDE_STEP_RST   = 23'd629146;
  localparam logic [STEP_W-1:0] NARROW_STEP_RST = 23'd41943;

  typedef enum logic [1:0] {
    OP_FM_WIDE,
    OP_FM_NARROW,
    OP_AM
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [AMP_W-1:0]   amp;
  } fmam_op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ACC,
    B_SIN,
    B_COS,
    B_EMIT
  } back_state_t;

  // Quarter pi in Q30 is not needed; the table spans half pi in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
    logic [63:0] q;
    case (n)
      1:       q = term / 64'd6;
      2:       q = term / 64'd20;
      3:       q = term / 64'd42;
      4:       q = term / 64'd72;
      5:       q = term / 64'd110;
      6:       q = term / 64'd156;
      7:       q = term / 64'd210;
      8:       q = term / 64'd272;
      9:       q = term / 64'd342;
      10:      q = term / 64'd420;
      11:      q = term / 64'd506;
      default: q = term;
    endcase
    return q;
  endfunction

  // One entry of the quarter-wave table: floor(127 * sin(pi/2 * k / 2^tbits)),
  // evaluated with a Q30 Taylor series. Called with constants only.
  function automatic logic [MAG_W-1:0] sine_entry(input int k, input int tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n < 12; n++) begin
      term = (term * x2) >> 30;
      term = taylor_div(term, n);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd127) >> 30;
    if (k == 0) begin
      v = 64'd0;
    end
    if ((k == (1 << tbits)) || (v > 64'd127)) begin
      v = 64'd127;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

>>> design/fmam_sine_rom.sv
module fmam_sine_rom import fmam_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [TABLE_ADDR_BITS:0] addr,
  output logic [MAG_W-1:0]         data
);

  localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;

  logic [MAG_W-1:0] rom_table [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    assign rom_table[g] = sine_entry(g, TABLE_ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= rom_table[addr];
    end
  end

endmodule

>>> design/fmam_queue.sv
module fmam_queue import fmam_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fmam_op_t push_op,
  output logic     full,
  input  logic     pop,
  output fmam_op_t head_op,
  output logic     empty
);

  fmam_op_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_PTR_W:0]     count;

  assign full    = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QUEUE_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QUEUE_PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

>>> design/fmam_front.sv
module fmam_front import fmam_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [AUDIO_W-1:0]  audio_sample,
  input  logic [MODE_W-1:0]          mode,
  input  logic [GAIN_W-1:0]          audio_gain,
  output logic                       push,
  output fmam_op_t                   push_op,
  input  logic                       queue_full
);

  localparam logic signed [PROD_W-1:0] SAT_HI =
    PROD_W'(1) <<< (AMP_FRAC_BITS + GAIN_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI;
  localparam logic [AMP_W-1:0] AMP_POS_FULL = AMP_W'(1) << AMP_FRAC_BITS;
  localparam logic [AMP_W-1:0] AMP_NEG_FULL = ~AMP_POS_FULL + 1'b1;

  logic                       prod_valid;
  logic signed [PROD_W-1:0]   prod;
  op_kind_t                   prod_kind;
  logic signed [PROD_W-1:0]   prod_next;
  logic [AMP_W-1:0]           amp;
  op_kind_t                   kind_next;

  assign in_ready  = !prod_valid || !queue_full;
  assign push      = prod_valid && !queue_full;
  assign prod_next = audio_sample * $signed({1'b0, audio_gain});

  always_comb begin
    if (mode[1]) begin
      kind_next = OP_AM;
    end else if (mode == MODE_WIDE) begin
      kind_next = OP_FM_WIDE;
    end else begin
      kind_next = OP_FM_NARROW;
    end
  end

  // Saturate to +-1.0; in range, dropping the gain's fraction bits is a floor.
  always_comb begin
    if (prod > SAT_HI) begin
      amp = AMP_POS_FULL;
    end else if (prod < SAT_LO) begin
      amp = AMP_NEG_FULL;
    end else begin
      amp = prod[GAIN_FRAC_BITS +: AMP_W];
    end
  end

  assign push_op = '{kind: prod_kind, amp: amp};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      prod_valid <= 1'b1;
    end else if (push) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod      <= prod_next;
      prod_kind <= kind_next;
    end
  end

endmodule

>>> design/fmam_back.sv
module fmam_back import fmam_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [STEP_W-1:0]          wide_step,
  input  logic [STEP_W-1:0]          narrow_step,
  input  fmam_op_t                   head_op,
  input  logic                       queue_empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] i_sample,
  output logic signed [SAMPLE_W-1:0] q_sample
);

  localparam int EXT_W = (PHASE_BITS > DELTA_W) ? PHASE_BITS : DELTA_W;
  localparam logic [TABLE_ADDR_BITS:0] ROM_N = (TABLE_ADDR_BITS + 1)'(1) << TABLE_ADDR_BITS;
  localparam logic signed [MUL_A_W-1:0] AM_SCALE = MUL_A_W'(127);

  back_state_t                 state;
  back_state_t                 state_next;
  op_kind_t                    kind_q;
  logic signed [AMP_W-1:0]     amp_q;
  logic signed [MUL_W-1:0]     mul_q;
  logic [PHASE_BITS-1:0]       phase;
  logic [SAMPLE_W-1:0]         sin_val;

  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]     mul_res;
  logic signed [DELTA_W-1:0]   delta;
  logic signed [EXT_W-1:0]     delta_ext;
  logic [1:0]                  quad;
  logic [TABLE_ADDR_BITS-1:0]  k;
  logic [TABLE_ADDR_BITS:0]    k_up;
  logic [TABLE_ADDR_BITS:0]    k_down;
  logic                        rom_rd;
  logic [TABLE_ADDR_BITS:0]    rom_addr;
  logic [MAG_W-1:0]            rom_data;
  logic [SAMPLE_W-1:0]         rom_pos;
  logic [SAMPLE_W-1:0]         rom_neg;
  logic [SAMPLE_W-1:0]         cos_val;
  logic [SAMPLE_W-1:0]         am_i;
  logic [SAMPLE_W-1:0]         am_fix;
  logic                        load_out;

  // One multiplier serves both modes.
  always_comb begin
    unique case (kind_q)
      OP_AM:        mul_a = AM_SCALE;
      OP_FM_WIDE:   mul_a = $signed({1'b0, wide_step});
      OP_FM_NARROW: mul_a = $signed({1'b0, narrow_step});
      default:      mul_a = AM_SCALE;
    endcase
  end

  assign mul_res   = mul_a * amp_q;
  assign delta     = mul_q[MUL_W-1:AMP_FRAC_BITS];
  assign delta_ext = EXT_W'(delta);

  assign quad   = phase[PHASE_BITS-1 -: 2];
  assign k      = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign k_up   = {1'b0, k};
  assign k_down = ROM_N - k_up;

  // Odd quadrants run the table backwards; the cosine quadrant is one on.
  always_comb begin
    rom_rd   = 1'b0;
    rom_addr = k_up;
    if (state == B_SIN) begin
      rom_rd   = 1'b1;
      rom_addr = quad[0] ? k_down : k_up;
    end else if (state == B_COS) begin
      rom_rd   = 1'b1;
      rom_addr = quad[0] ? k_up : k_down;
    end
  end

  fmam_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk   (clk),
    .rd_en (rom_rd),
    .addr  (rom_addr),
    .data  (rom_data)
  );

  assign rom_pos = {1'b0, rom_data};
  assign rom_neg = SAMPLE_W'(0) - rom_pos;
  assign cos_val = (quad[1] ^ quad[0]) ? rom_neg : rom_pos;

  // AM output truncates towards zero: add one to the floor of a negative
  // product that has a remainder.
  assign am_fix = {{(SAMPLE_W-1){1'b0}}, mul_q[MUL_W-1] & (|mul_q[AMP_FRAC_BITS-1:0])};
  assign am_i   = mul_q[AMP_FRAC_BITS +: SAMPLE_W] + am_fix;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!queue_empty) begin
          pop        = 1'b1;
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        state_next = B_ACC;
        if (kind_q == OP_AM) begin
          state_next = B_EMIT;
        end
      end
      B_ACC: begin
        state_next = B_SIN;
      end
      B_SIN: begin
        state_next = B_COS;
      end
      B_COS: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_ACC) begin
        phase <= phase + delta_ext[PHASE_BITS-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_q <= head_op.kind;
      amp_q  <= $signed(head_op.amp);
    end
    if (state == B_MUL) begin
      mul_q <= mul_res;
    end
    if (state == B_COS) begin
      sin_val <= quad[1] ? rom_neg : rom_pos;
    end
    if (load_out) begin
      if (kind_q == OP_AM) begin
        i_sample <= am_i;
        q_sample <= '0;
      end else begin
        i_sample <= sin_val;
        q_sample <= cos_val;
      end
    end
  end

endmodule

>>> design/fm_am_iq_modulator.sv
// FM / AM IQ modulator. Each request on the input channel carries one signed
// Q1.15 audio sample, and each yields exactly one request on the output
// channel with a signed 8-bit I and Q pair. The sample is scaled by the
// unsigned Q8.8 audio gain and saturated to plus or minus 1.0. In the two FM
// modes the scaled amplitude times the selected phase step moves a phase
// accumulator, and I and Q are the sine and cosine of the new phase, read
// from a quarter-wave table and scaled to 127. In AM mode I is the amplitude
// scaled to 127 (truncated towards zero), Q is zero and the phase is held.
// Mode value three behaves as AM. The front part multiplies by the gain and
// saturates, then hands the work to the back part through a two-entry
// queue; the back part runs one request at a time on a shared multiplier
// and a single-port table, stepping through dequeue, multiply, phase update,
// sine read, cosine read and output for an FM request and through dequeue,
// multiply and output for an AM request, and it takes no new request until
// the last one has been output. The output register holds a finished
// result while further requests queue up behind it. Configuration writes are
// always accepted and must be made only while the block is idle; writes to an
// index beyond the last register are ignored.
module fm_am_iq_modulator import fmam_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,

  // Configuration port.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,

  // Audio input.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [AUDIO_W-1:0]  audio_sample,

  // IQ output.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] i_sample,
  output logic signed [SAMPLE_W-1:0] q_sample
);

  // Configuration registers.
  logic [MODE_W-1:0] mode;
  logic [GAIN_W-1:0] audio_gain;
  logic [STEP_W-1:0] wide_step;
  logic [STEP_W-1:0] narrow_step;

  // Front to queue, queue to back.
  logic     push;
  fmam_op_t push_op;
  logic     queue_full;
  logic     pop;
  fmam_op_t head_op;
  logic     queue_empty;

  assign cfg_ready = 1'b1;

  // The register file takes a write on every cycle; an unknown index is
  // simply dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_RST;
      audio_gain  <= AUDIO_GAIN_RST;
      wide_step   <= WIDE_STEP_RST;
      narrow_step <= NARROW_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:        mode        <= cfg_data[MODE_W-1:0];
        REG_AUDIO_GAIN:  audio_gain  <= cfg_data[GAIN_W-1:0];
        REG_WIDE_STEP:   wide_step   <= cfg_data[STEP_W-1:0];
        REG_NARROW_STEP: narrow_step <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: gain multiply, saturation and classification by mode.
  fmam_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .audio_sample (audio_sample),
    .mode         (mode),
    .audio_gain   (audio_gain),
    .push         (push),
    .push_op      (push_op),
    .queue_full   (queue_full)
  );

  // The queue lets the front keep taking samples while the back is busy.
  fmam_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (queue_full),
    .pop     (pop),
    .head_op (head_op),
    .empty   (queue_empty)
  );

  // Back: phase accumulator, sine table and the output register.
  fmam_back #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wide_step   (wide_step),
    .narrow_step (narrow_step),
    .head_op     (head_op),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .i_sample    (i_sample),
    .q_sample    (q_sample)
  );

endmodule
